>>> rtl/lpg_pkg.sv
// Package for the line point generator.
// Holds coordinate widths, the controller/datapath command and status structs,
// and the coordinate clamp function. It depends on nothing else.
`timescale 1ns / 1ps

package lpg_pkg;

  // Coordinate geometry.
  localparam int COORD_W   = 6;
  localparam int COORD_MAX = 63;
  // The error term stays within about twice the largest delta.
  localparam int ERR_W     = COORD_W + 2;
  localparam int E2_W      = ERR_W + 1;

  typedef logic [COORD_W-1:0] coord_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // Capture a new command and set up the walk.
    logic emit;   // Move the current point to the output and advance.
  } lpg_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic at_end; // The current point equals the end point.
  } lpg_status_t;

  // Saturate a coordinate to the allowed maximum.
  function automatic coord_t clamp_coord(input coord_t c);
    coord_t r;
    if (COORD_W'(COORD_MAX) < c) begin
      r = COORD_W'(COORD_MAX);
    end else begin
      r = c;
    end
    return r;
  endfunction

endpackage

>>> rtl/line_point_generator_unit.sv
// Line point generator: one beat of start/end coordinates in, one beat per
// grid point of the line out, the last one flagged.
// The command beat puts the controller in its run state, and each point passes
// through the output point register. A single step unit advances the walk one
// point per cycle unless the output stalls; a new command waits for the end point.
// Reset (synchronous, active high) returns the controller to idle, output empty.
`timescale 1ns / 1ps

module line_point_generator_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  lpg_pkg::coord_t start_x,
  input  lpg_pkg::coord_t start_y,
  input  lpg_pkg::coord_t end_x,
  input  lpg_pkg::coord_t end_y,
  output logic            out_valid,
  input  logic            out_ready,
  output lpg_pkg::coord_t point_x,
  output lpg_pkg::coord_t point_y,
  output logic            last_point
);
  import lpg_pkg::*;

  lpg_cmd_t    cmd;
  lpg_status_t status;

  // Sequencing of command and output beats.
  lpg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  // Line walk and output point register.
  lpg_datapath u_datapath (
    .clk        (clk),
    .cmd        (cmd),
    .status     (status),
    .start_x    (start_x),
    .start_y    (start_y),
    .end_x      (end_x),
    .end_y      (end_y),
    .point_x    (point_x),
    .point_y    (point_y),
    .last_point (last_point)
  );

endmodule

>>> rtl/lpg_datapath.sv
// Datapath of the line point generator: the error-term line walk registers
// and the output point register. Depends on lpg_pkg; driven by lpg_ctrl.
`timescale 1ns / 1ps

module lpg_datapath (
  input  logic                clk,
  input  lpg_pkg::lpg_cmd_t   cmd,
  output lpg_pkg::lpg_status_t status,
  input  lpg_pkg::coord_t     start_x,
  input  lpg_pkg::coord_t     start_y,
  input  lpg_pkg::coord_t     end_x,
  input  lpg_pkg::coord_t     end_y,
  output lpg_pkg::coord_t     point_x,
  output lpg_pkg::coord_t     point_y,
  output logic                last_point
);
  import lpg_pkg::*;

  // Walk state.
  coord_t                  cur_x;
  coord_t                  cur_y;
  coord_t                  tgt_x;
  coord_t                  tgt_y;
  coord_t                  dx;
  coord_t                  dy;
  logic                    x_neg;
  logic                    y_neg;
  logic signed [ERR_W-1:0] err;

  // Setup values for a new command.
  coord_t                  sx_in;
  coord_t                  sy_in;
  coord_t                  ex_in;
  coord_t                  ey_in;
  coord_t                  dx_in;
  coord_t                  dy_in;

  // Step decision.
  logic signed [E2_W-1:0]  e2;
  logic signed [E2_W-1:0]  dx_s;
  logic signed [E2_W-1:0]  dy_s;
  logic                    step_x;
  logic                    step_y;
  logic signed [ERR_W-1:0] err_next;
  coord_t                  cur_x_next;
  coord_t                  cur_y_next;

  // Clamp inputs and form the absolute deltas.
  always_comb begin
    sx_in = clamp_coord(start_x);
    sy_in = clamp_coord(start_y);
    ex_in = clamp_coord(end_x);
    ey_in = clamp_coord(end_y);
    dx_in = (sx_in > ex_in) ? sx_in - ex_in : ex_in - sx_in;
    dy_in = (sy_in > ey_in) ? sy_in - ey_in : ey_in - sy_in;
  end

  // One step of the walk: compare the doubled error with -dy and dx.
  always_comb begin
    e2     = {err, 1'b0};
    dx_s   = $signed({{(E2_W-COORD_W){1'b0}}, dx});
    dy_s   = $signed({{(E2_W-COORD_W){1'b0}}, dy});
    step_x = e2 > -dy_s;
    step_y = e2 < dx_s;
    err_next = err
             - (step_x ? $signed({{(ERR_W-COORD_W){1'b0}}, dy}) : ERR_W'(0))
             + (step_y ? $signed({{(ERR_W-COORD_W){1'b0}}, dx}) : ERR_W'(0));
    cur_x_next = cur_x;
    if (step_x) begin
      cur_x_next = x_neg ? cur_x - COORD_W'(1) : cur_x + COORD_W'(1);
    end
    cur_y_next = cur_y;
    if (step_y) begin
      cur_y_next = y_neg ? cur_y - COORD_W'(1) : cur_y + COORD_W'(1);
    end
  end

  assign status.at_end = (cur_x == tgt_x) && (cur_y == tgt_y);

  // Walk registers: loaded on a new command, advanced on each emitted point.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_x <= sx_in;
      cur_y <= sy_in;
      tgt_x <= ex_in;
      tgt_y <= ey_in;
      dx    <= dx_in;
      dy    <= dy_in;
      x_neg <= sx_in > ex_in;
      y_neg <= sy_in > ey_in;
      err   <= $signed({2'b00, dx_in}) - $signed({2'b00, dy_in});
    end else if (cmd.emit) begin
      cur_x <= cur_x_next;
      cur_y <= cur_y_next;
      err   <= err_next;
    end
  end

  // Output point register.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      point_x    <= cur_x;
      point_y    <= cur_y;
      last_point <= status.at_end;
    end
  end

endmodule

>>> rtl/lpg_ctrl.sv
// Controller of the line point generator: the command state machine and the
// output beat valid flag. Depends on lpg_pkg; drives lpg_datapath.
`timescale 1ns / 1ps

module lpg_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output lpg_pkg::lpg_cmd_t    cmd,
  input  lpg_pkg::lpg_status_t status
);
  import lpg_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t state;
  logic   slot_free;

  // The output register can take a point when empty or being drained.
  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == ST_IDLE);

  always_comb begin
    cmd.load = in_valid && in_ready;
    cmd.emit = (state == ST_RUN) && slot_free;
  end

  // State and output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (cmd.load) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (cmd.emit && status.at_end) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // An accepted command starts a walk in the next cycle.
  a_load_starts_run: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == ST_RUN))
    else $error("accepted command did not start a walk");

  // A point is never written over an output beat that is still waiting.
  a_emit_into_free_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("point emitted over a pending output beat");

  // Emitting the end point closes the walk.
  a_end_returns_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && status.at_end) |=> (state == ST_IDLE))
    else $error("walk did not close after the end point");

  // No command is taken while a walk is in progress.
  a_no_load_in_run: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> !cmd.load)
    else $error("command accepted during a walk");
`endif

endmodule

>>> bench/tb.sv
// Self-checking testbench for line_point_generator_unit: line commands go in,
// every grid point of each line is predicted or typed in and compared beat by beat.
// Depends on lpg_pkg and the line_point_generator_unit RTL.
`timescale 1ns / 1ps

module tb;

  import lpg_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 11;
  localparam int RANDOM_LINES = 500;
  localparam int QUIET_LINES  = 60;   // Final stretch with no idling on either side.
  localparam int HOLD_AT_LINE = 150;  // Random line at which the long receiver hold starts.
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 16;
  localparam int STALL_LIMIT  = 4000;
  localparam int DIR_ROWS     = 24;

  // One grid point as the block reports it.
  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
  } grid_point_t;

  // How a directed row is checked: against the predictor, or against the
  // single point typed into the row.
  typedef enum logic {
    CHECK_MODEL,
    CHECK_TYPED
  } row_check_t;

  typedef struct packed {
    row_check_t check;
    coord_t     sx;
    coord_t     sy;
    coord_t     ex;
    coord_t     ey;
    coord_t     px;
    coord_t     py;
  } line_row_t;

  logic   clk        = 1'b0;
  logic   rst        = 1'b1;
  logic   in_valid   = 1'b0;
  logic   in_ready;
  coord_t start_x    = '0;
  coord_t start_y    = '0;
  coord_t end_x      = '0;
  coord_t end_y      = '0;
  logic   out_valid;
  logic   out_ready  = 1'b0;
  coord_t point_x;
  coord_t point_y;
  logic   last_point;

  // Points still owed by the block, oldest first.
  grid_point_t line_points_due[$];
  grid_point_t head_point;

  int  lines_sent   = 0;
  int  points_seen  = 0;
  int  lines_closed = 0;
  int  mismatches   = 0;
  int  idle_cycles  = 0;
  bit  quiet        = 1'b0;
  bit  hold_req     = 1'b0;

  // Directed lines: zero-length lines carry their one point typed in.
  line_row_t dir_table [0:DIR_ROWS-1] = '{
    '{CHECK_TYPED,  0,  0,  0,  0,  0,  0},
    '{CHECK_TYPED, 63, 63, 63, 63, 63, 63},
    '{CHECK_TYPED, 21, 42, 21, 42, 21, 42},
    '{CHECK_MODEL,  0,  0, 63,  0,  0,  0},
    '{CHECK_MODEL, 63,  5,  0,  5,  0,  0},
    '{CHECK_MODEL,  7,  0,  7, 63,  0,  0},
    '{CHECK_MODEL,  9, 63,  9,  0,  0,  0},
    '{CHECK_MODEL,  0,  0, 63, 63,  0,  0},
    '{CHECK_MODEL, 63, 63,  0,  0,  0,  0},
    '{CHECK_MODEL,  0, 63, 63,  0,  0,  0},
    '{CHECK_MODEL, 63,  0,  0, 63,  0,  0},
    '{CHECK_MODEL, 30, 30, 40, 34,  0,  0},
    '{CHECK_MODEL, 30, 30, 34, 40,  0,  0},
    '{CHECK_MODEL, 30, 30, 26, 40,  0,  0},
    '{CHECK_MODEL, 30, 30, 20, 34,  0,  0},
    '{CHECK_MODEL, 30, 30, 20, 26,  0,  0},
    '{CHECK_MODEL, 30, 30, 26, 20,  0,  0},
    '{CHECK_MODEL, 30, 30, 34, 20,  0,  0},
    '{CHECK_MODEL, 30, 30, 40, 26,  0,  0},
    '{CHECK_MODEL,  0,  0, 63,  1,  0,  0},
    '{CHECK_MODEL,  0,  0,  1, 63,  0,  0},
    '{CHECK_MODEL, 10, 10, 11, 10,  0,  0},
    '{CHECK_MODEL, 10, 10, 11, 11,  0,  0},
    '{CHECK_MODEL, 42, 21, 21, 42,  0,  0}
  };

  line_point_generator_unit u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .start_x    (start_x),
    .start_y    (start_y),
    .end_x      (end_x),
    .end_y      (end_y),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .point_x    (point_x),
    .point_y    (point_y),
    .last_point (last_point)
  );

  always #CLK_HALF clk = ~clk;

  // Walk the error term from start to end and queue every point it visits.
  function automatic void trace_line_points(input coord_t x0, input coord_t y0,
                                            input coord_t x1, input coord_t y1);
    int x, y, xe, ye, dx, dy, sx, sy, err, e2, n;
    bit done;
    grid_point_t pt;
    x  = (x0 > COORD_MAX) ? COORD_MAX : x0;
    y  = (y0 > COORD_MAX) ? COORD_MAX : y0;
    xe = (x1 > COORD_MAX) ? COORD_MAX : x1;
    ye = (y1 > COORD_MAX) ? COORD_MAX : y1;
    dx = (x > xe) ? x - xe : xe - x;
    sx = (x > xe) ? -1 : 1;
    dy = (y > ye) ? y - ye : ye - y;
    sy = (y > ye) ? -1 : 1;
    err = dx - dy;
    n = 0;
    done = 1'b0;
    while (!done && n < COORD_MAX + 1) begin
      done = (x == xe) && (y == ye);
      pt.x = coord_t'(x);
      pt.y = coord_t'(y);
      pt.last = done;
      line_points_due.push_back(pt);
      n++;
      if (!done) begin
        e2 = err * 2;
        if (e2 > -dy) begin
          err -= dy;
          x += sx;
        end
        if (e2 < dx) begin
          err += dx;
          y += sy;
        end
      end
    end
  endfunction

  // Present one command and hold it until the block takes the beat.
  task automatic offer_line(input coord_t sx, input coord_t sy,
                            input coord_t ex, input coord_t ey);
    in_valid <= 1'b1;
    start_x  <= sx;
    start_y  <= sy;
    end_x    <= ex;
    end_y    <= ey;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    lines_sent++;
  endtask

  // Sometimes leave the input idle for a burst after a beat.
  task automatic sender_gap();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  // Keep a coordinate inside the grid after an offset.
  function automatic coord_t near_coord(input coord_t c, input int off);
    int t;
    t = c + off;
    if (t < 0) t = 0;
    if (t > COORD_MAX) t = COORD_MAX;
    return coord_t'(t);
  endfunction

  // Receiver: random stalls, one long hold on request, steady at the end.
  initial begin
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // Compare each output beat with the oldest point still owed.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      points_seen++;
      if (last_point === 1'b1) lines_closed++;
      if (line_points_due.size() == 0) begin
        $error("point (%0d,%0d) arrived with no point outstanding", point_x, point_y);
        mismatches++;
      end else begin
        head_point = line_points_due.pop_front();
        if (point_x !== head_point.x) begin
          $error("point_x: expected %0d, got %0d", head_point.x, point_x);
          mismatches++;
        end
        if (point_y !== head_point.y) begin
          $error("point_y: expected %0d, got %0d", head_point.y, point_y);
          mismatches++;
        end
        if (last_point !== head_point.last) begin
          $error("last_point: expected %0b, got %0b", head_point.last, last_point);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on cycles where neither channel moves a beat.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $error("no beat accepted for %0d cycles", STALL_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Main sequence: reset, directed table, random lines, drain, verdict.
  initial begin
    coord_t sx, sy, ex, ey;
    grid_point_t typed_pt;
    int kind;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed lines: axes, diagonals, every octant and the grid corners.
    for (int i = 0; i < DIR_ROWS; i++) begin
      offer_line(dir_table[i].sx, dir_table[i].sy, dir_table[i].ex, dir_table[i].ey);
      if (dir_table[i].check == CHECK_TYPED) begin
        typed_pt.x = dir_table[i].px;
        typed_pt.y = dir_table[i].py;
        typed_pt.last = 1'b1;
        line_points_due.push_back(typed_pt);
      end else begin
        trace_line_points(dir_table[i].sx, dir_table[i].sy,
                          dir_table[i].ex, dir_table[i].ey);
      end
      sender_gap();
    end

    // Random lines: mostly anywhere on the grid, some short, some degenerate.
    for (int i = 0; i < RANDOM_LINES; i++) begin
      if (i == HOLD_AT_LINE) hold_req = 1'b1;
      if (i == RANDOM_LINES - QUIET_LINES) quiet = 1'b1;
      kind = $urandom_range(0, 19);
      sx = coord_t'($urandom_range(0, COORD_MAX));
      sy = coord_t'($urandom_range(0, COORD_MAX));
      if (kind < 12) begin
        ex = coord_t'($urandom_range(0, COORD_MAX));
        ey = coord_t'($urandom_range(0, COORD_MAX));
      end else if (kind < 18) begin
        ex = near_coord(sx, $urandom_range(0, 8) - 4);
        ey = near_coord(sy, $urandom_range(0, 8) - 4);
      end else begin
        ex = sx;
        ey = sy;
      end
      offer_line(sx, sy, ex, ey);
      trace_line_points(sx, sy, ex, ey);
      sender_gap();
    end
    in_valid <= 1'b0;

    // Wait for every owed point, then watch a while for strays.
    while (line_points_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d line commands (%0d from the directed table) in all octants,",
             lines_sent, DIR_ROWS);
    $display("with %0d points checked over %0d closed lines; %0d mismatches.",
             points_seen, lines_closed, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
